// ===== hw/rtl/isa_pkg.sv =====
// Shared types, command and status codes for the indexed shift array.
`default_nettype none

package isa_pkg;

	// Default depth of the array and the widest entry index width it supports
	localparam int DEFAULT_CAPACITY = 256;
	localparam int MAX_IDX_W        = 12;

	// Command codes
	localparam logic [3:0] CMD_APPEND       = 4'd0;
	localparam logic [3:0] CMD_INSERT_AT    = 4'd1;
	localparam logic [3:0] CMD_PREPEND      = 4'd2;
	localparam logic [3:0] CMD_REMOVE_LAST  = 4'd3;
	localparam logic [3:0] CMD_REMOVE_AT    = 4'd4;
	localparam logic [3:0] CMD_REMOVE_FIRST = 4'd5;
	localparam logic [3:0] CMD_GET          = 4'd6;
	localparam logic [3:0] CMD_SET          = 4'd7;
	localparam logic [3:0] CMD_FIND         = 4'd8;

	// Status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_OOB   = 2'd2;
	localparam logic [1:0] STATUS_FULL  = 2'd3;

	// Cell operations broadcast along the chain
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;
	localparam logic [1:0] CELL_WRITE  = 2'd3;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [7:0]  position;
		logic [63:0] word;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_word;
		logic        found;
		logic [7:0]  found_position;
		logic [8:0]  count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [MAX_IDX_W-1:0] pos;
		logic [63:0]          word;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/isa_cell.sv =====
// One storage cell of the array: holds one word, shifts with its neighbors.
`default_nettype none

module isa_cell #(
	parameter int IDX_W = 8,
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire isa_pkg::cell_ctl_t ctl,
	input  wire logic [63:0]       left_word,
	input  wire logic [63:0]       right_word,
	output logic [63:0]            word_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [IDX_W-1:0] sel;
	logic [63:0]      word_nxt;

	assign sel = ctl.pos[IDX_W-1:0];

	// Pick the next word: hold, take from a neighbor, or load
	always_comb begin
		word_nxt = word_q;
		unique case (ctl.op)
			isa_pkg::CELL_HOLD: begin
				word_nxt = word_q;
			end
			isa_pkg::CELL_INSERT: begin
				if (MY_IDX > sel) begin
					word_nxt = left_word;
				end else if (MY_IDX == sel) begin
					word_nxt = ctl.word;
				end
			end
			isa_pkg::CELL_REMOVE: begin
				if (MY_IDX >= sel) begin
					word_nxt = right_word;
				end
			end
			isa_pkg::CELL_WRITE: begin
				if (MY_IDX == sel) begin
					word_nxt = ctl.word;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/isa_chain.sv =====
// Row of storage cells wired as a ring; cell 0 is the head seen by the scan.
`default_nettype none

module isa_chain #(
	parameter int CAPACITY = isa_pkg::DEFAULT_CAPACITY,
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  wire logic               clk,
	input  wire isa_pkg::cell_ctl_t ctl,
	output logic [63:0]             head_word
);

	logic [63:0] cell_word [CAPACITY];

	// Each cell sees its lower and upper neighbor; the ends wrap around
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? CAPACITY - 1 : i - 1;
		localparam int RIGHT = (i == CAPACITY - 1) ? 0 : i + 1;

		isa_cell #(
			.IDX_W(IDX_W),
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_word (cell_word[LEFT]),
			.right_word(cell_word[RIGHT]),
			.word_q    (cell_word[i])
		);
	end

	assign head_word = cell_word[0];

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_shift_array_core.sv =====
// Top level of the indexed shift array: command decode, scan control, response register.
// Ordered array of up to CAPACITY 64-bit words held in a ring of cells. Append,
// insert, prepend, the three removes and set need no scan: the command is
// decoded on acceptance, every cell shifts or loads at the same edge, and the
// response is registered at that edge. Get (in bounds) and find scan the ring:
// it rotates once through cell 0, the word in cell 0 is compared or captured at
// each step, and the response is registered at the end of the full turn, which
// also puts every entry back in place. One command is in the block at a time; a
// new one is taken in the cycle the previous response leaves. Entries never
// written read as garbage; no clearing pass is needed after reset.
`default_nettype none

module indexed_shift_array_core #(
	parameter int CAPACITY = isa_pkg::DEFAULT_CAPACITY
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire isa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output isa_pkg::rsp_t      rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CAPACITY - 1);

	logic                state_q;
	logic [CNT_W-1:0]    count_q;
	logic                rsp_valid_q;
	isa_pkg::rsp_t       rsp_q;

	logic [IDX_W-1:0]    k_q;
	logic                scan_find_q;
	logic [IDX_W-1:0]    scan_idx_q;
	logic [63:0]         scan_word_q;
	logic                found_q;
	logic [IDX_W-1:0]    fpos_q;
	logic [63:0]         rd_q;

	logic                accept;
	logic [CMP_W-1:0]    pos_ext;
	logic [IDX_W-1:0]    pos_idx;
	logic                in_bounds;
	logic                is_full;
	logic                is_empty;
	logic [1:0]          dec_op;
	logic [IDX_W-1:0]    dec_pos;
	logic [CNT_W-1:0]    count_nxt;
	logic [1:0]          dec_status;
	logic                start_scan;
	isa_pkg::cell_ctl_t  ctl;
	logic [63:0]         head_word;

	logic                hit_find;
	logic                hit_get;
	logic                scan_last;
	logic                found_nxt;
	logic [IDX_W-1:0]    fpos_nxt;
	logic [63:0]         rd_nxt;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Bounds and fill checks
	assign pos_ext   = CMP_W'(req.position);
	assign pos_idx   = pos_ext[IDX_W-1:0];
	assign in_bounds = pos_ext < CMP_W'(count_q);
	assign is_full   = count_q == FULL_COUNT;
	assign is_empty  = count_q == '0;

	// Decode the command into a cell operation, a new count and a status
	always_comb begin
		dec_op     = isa_pkg::CELL_HOLD;
		dec_pos    = '0;
		count_nxt  = count_q;
		dec_status = isa_pkg::STATUS_OK;
		start_scan = 1'b0;
		unique case (req.cmd)
			isa_pkg::CMD_APPEND: begin
				if (is_full) begin
					dec_status = isa_pkg::STATUS_FULL;
				end else begin
					dec_op    = isa_pkg::CELL_INSERT;
					dec_pos   = count_q[IDX_W-1:0];
					count_nxt = count_q + 1'b1;
				end
			end
			isa_pkg::CMD_INSERT_AT: begin
				if (!in_bounds) begin
					dec_status = isa_pkg::STATUS_OOB;
				end else if (is_full) begin
					dec_status = isa_pkg::STATUS_FULL;
				end else begin
					dec_op    = isa_pkg::CELL_INSERT;
					dec_pos   = pos_idx;
					count_nxt = count_q + 1'b1;
				end
			end
			isa_pkg::CMD_PREPEND: begin
				if (is_full) begin
					dec_status = isa_pkg::STATUS_FULL;
				end else begin
					dec_op    = isa_pkg::CELL_INSERT;
					count_nxt = count_q + 1'b1;
				end
			end
			isa_pkg::CMD_REMOVE_LAST: begin
				if (is_empty) begin
					dec_status = isa_pkg::STATUS_EMPTY;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			isa_pkg::CMD_REMOVE_AT: begin
				if (!in_bounds) begin
					dec_status = isa_pkg::STATUS_OOB;
				end else begin
					dec_op    = isa_pkg::CELL_REMOVE;
					dec_pos   = pos_idx;
					count_nxt = count_q - 1'b1;
				end
			end
			isa_pkg::CMD_REMOVE_FIRST: begin
				if (is_empty) begin
					dec_status = isa_pkg::STATUS_OOB;
				end else begin
					dec_op    = isa_pkg::CELL_REMOVE;
					count_nxt = count_q - 1'b1;
				end
			end
			isa_pkg::CMD_GET: begin
				if (!in_bounds) begin
					dec_status = isa_pkg::STATUS_OOB;
				end else begin
					start_scan = 1'b1;
				end
			end
			isa_pkg::CMD_SET: begin
				if (!in_bounds) begin
					dec_status = isa_pkg::STATUS_OOB;
				end else begin
					dec_op  = isa_pkg::CELL_WRITE;
					dec_pos = pos_idx;
				end
			end
			isa_pkg::CMD_FIND: begin
				start_scan = 1'b1;
			end
			default: begin
				dec_status = isa_pkg::STATUS_OK;
			end
		endcase
	end

	// Drive the chain: decoded op on acceptance, rotate by one while scanning
	always_comb begin
		ctl.word = req.word;
		ctl.pos  = '0;
		ctl.op   = isa_pkg::CELL_HOLD;
		if (state_q == S_SCAN) begin
			ctl.op = isa_pkg::CELL_REMOVE;
		end else if (accept) begin
			ctl.op  = dec_op;
			ctl.pos = isa_pkg::MAX_IDX_W'(dec_pos);
		end
	end

	isa_chain #(
		.CAPACITY(CAPACITY),
		.IDX_W   (IDX_W)
	) u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.head_word(head_word)
	);

	// Examine the head cell; after k rotations it holds original entry k
	assign hit_find  = scan_find_q && !found_q && (CNT_W'(k_q) < count_q) &&
		(head_word == scan_word_q);
	assign hit_get   = !scan_find_q && (k_q == scan_idx_q);
	assign scan_last = k_q == LAST_IDX;
	assign found_nxt = found_q | hit_find;
	assign fpos_nxt  = hit_find ? k_q : fpos_q;
	assign rd_nxt    = hit_get ? head_word : rd_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (state_q == S_SCAN) begin
				k_q <= k_q + 1'b1;
				if (scan_last) begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
			end else if (accept) begin
				count_q <= count_nxt;
				if (start_scan) begin
					state_q     <= S_SCAN;
					k_q         <= '0;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b1;
				end
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Scan and response payload
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			found_q <= found_nxt;
			fpos_q  <= fpos_nxt;
			rd_q    <= rd_nxt;
			if (scan_last) begin
				rsp_q.status         <= isa_pkg::STATUS_OK;
				rsp_q.read_word      <= rd_nxt;
				rsp_q.found          <= found_nxt;
				rsp_q.found_position <= 8'(fpos_nxt);
				rsp_q.count          <= 9'(count_q);
			end
		end else if (accept) begin
			if (start_scan) begin
				scan_find_q <= req.cmd == isa_pkg::CMD_FIND;
				scan_idx_q  <= pos_idx;
				scan_word_q <= req.word;
				found_q     <= 1'b0;
				fpos_q      <= '0;
				rd_q        <= '0;
			end else begin
				rsp_q.status         <= dec_status;
				rsp_q.read_word      <= '0;
				rsp_q.found          <= 1'b0;
				rsp_q.found_position <= '0;
				rsp_q.count          <= 9'(count_nxt);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/isa_checker.sv =====
// Port-level checks for the indexed shift array, bound to the top level.
`default_nettype none

module isa_checker #(
	parameter int CAPACITY = isa_pkg::DEFAULT_CAPACITY
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire isa_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire isa_pkg::rsp_t rsp
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A full status only comes from a full array
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == isa_pkg::STATUS_FULL |-> rsp.count == 9'(CAPACITY))
		else $error("full status with array not full");

	// A miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.found_position == '0)
		else $error("position reported without a match");

	// A failed command returns no data and no match
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != isa_pkg::STATUS_OK |-> rsp.read_word == '0 && !rsp.found)
		else $error("data returned with error status");

	// Take no command while a response is stalled
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("command accepted over a stalled response");

endmodule

bind indexed_shift_array_core isa_checker #(
	.CAPACITY(CAPACITY)
) u_isa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire
